// File: rtl/vcod_pkg.sv
// shared types, constants and codes for the voxel column occupancy difference block
`default_nettype none
package vcod_pkg;

  localparam int Z_BITS              = 13;
  localparam int ZS_BITS             = Z_BITS + 2;
  localparam int TOTAL_BITS          = 48;
  localparam int MAX_TRANSITIONS_DEF = 64;
  localparam int CFG_INDEX_BITS      = 2;

  typedef logic [Z_BITS-1:0]         z_t;
  typedef logic signed [ZS_BITS-1:0] zs_t;
  typedef logic [TOTAL_BITS-1:0]     total_t;

  typedef enum logic [1:0] {
    REQ_LOAD_CARVED = 2'd0,
    REQ_LOAD_TARGET = 2'd1,
    REQ_FINISH      = 2'd2
  } req_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_Z_SHIFT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_Z_LIMIT = 2'd1;

  localparam z_t Z_LIMIT_RESET = z_t'(4096);

  typedef struct packed {
    req_t req_type;
    z_t   z_value;
    logic clear_totals;
  } in_item_t;

  typedef struct packed {
    total_t excess_total;
    total_t gouge_total;
    total_t carved_total;
    total_t target_total;
    logic   overflow;
  } out_item_t;

  typedef struct packed {
    logic load_carved;
    logic load_target;
    logic start;
    logic clear;
    logic walk;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/vcod_ram.sv
// generic single write port ram with registered read
`default_nettype none
module vcod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/vcod_ctrl.sv
// controller: request decode, column walk sequencing and result register handshake
`default_nettype none
module vcod_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire vcod_pkg::req_t        req_type,
  input  wire logic                  clear_totals,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output vcod_pkg::ctrl_cmd_t        cmd,
  input  wire vcod_pkg::dp_status_t  status
);
  import vcod_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    cmd.load_carved = accept && (req_type == REQ_LOAD_CARVED);
    cmd.load_target = accept && (req_type == REQ_LOAD_TARGET);
    cmd.start       = accept && (req_type == REQ_FINISH);
    cmd.clear       = cmd.start && clear_totals;
    cmd.walk        = (state == ST_WALK);
    // result register frees up once the previous beat is taken
    cmd.publish     = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (status.walk_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (cmd.publish) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/vcod_dp.sv
// datapath: transition lists, run walker, saturating totals and result register
`default_nettype none
module vcod_dp #(
  parameter int MAX_TRANSITIONS = vcod_pkg::MAX_TRANSITIONS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire vcod_pkg::ctrl_cmd_t                 cmd,
  output vcod_pkg::dp_status_t                     status,
  input  wire vcod_pkg::z_t                        z_value,
  input  wire logic                                cfg_we,
  input  wire logic [vcod_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire vcod_pkg::z_t                        cfg_data,
  output vcod_pkg::out_item_t                      out_item
);
  import vcod_pkg::*;

  localparam int AW = $clog2(MAX_TRANSITIONS);
  localparam int CW = $clog2(MAX_TRANSITIONS + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_TRANSITIONS);

  function automatic total_t sat_add(input total_t a, input z_t b);
    logic [TOTAL_BITS:0] s;
    s = {1'b0, a} + {{(TOTAL_BITS + 1 - Z_BITS){1'b0}}, b};
    return s[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : s[TOTAL_BITS-1:0];
  endfunction

  z_t            cfg_shift;
  z_t            cfg_limit;
  logic [CW-1:0] carved_count;
  logic [CW-1:0] target_count;
  logic          overflow_flag;
  logic [CW-1:0] ci, ci_next;
  logic [CW-1:0] ti, ti_next;
  logic          cin;
  logic          tin;
  z_t            z;
  total_t        excess_sum;
  total_t        gouge_sum;
  total_t        carved_sum;
  total_t        target_sum;

  z_t   c_head;
  z_t   t_head;
  logic c_wr;
  logic t_wr;
  logic c_val;
  logic t_val;
  zs_t  c_ext;
  zs_t  t_adj;
  zs_t  z_ext;
  zs_t  lim_ext;
  zs_t  shift_ext;
  zs_t  nxt;
  zs_t  run_diff;
  z_t   run_len;
  logic c_take;
  logic t_take;
  logic step;

  assign c_wr = cmd.load_carved && (carved_count != COUNT_FULL);
  assign t_wr = cmd.load_target && (target_count != COUNT_FULL);

  vcod_ram #(.WIDTH(Z_BITS), .DEPTH(MAX_TRANSITIONS)) u_carved_ram (
    .clk   (clk),
    .we    (c_wr),
    .waddr (carved_count[AW-1:0]),
    .wdata (z_value),
    .raddr (ci_next[AW-1:0]),
    .rdata (c_head)
  );

  vcod_ram #(.WIDTH(Z_BITS), .DEPTH(MAX_TRANSITIONS)) u_target_ram (
    .clk   (clk),
    .we    (t_wr),
    .waddr (target_count[AW-1:0]),
    .wdata (z_value),
    .raddr (ti_next[AW-1:0]),
    .rdata (t_head)
  );

  assign c_val     = (ci < carved_count);
  assign t_val     = (ti < target_count);
  assign c_ext     = {2'b00, c_head};
  assign shift_ext = {{2{cfg_shift[Z_BITS-1]}}, cfg_shift};
  assign t_adj     = zs_t'({2'b00, t_head}) - shift_ext;
  assign z_ext     = {2'b00, z};
  assign lim_ext   = {2'b00, cfg_limit};

  assign status.walk_done = (z >= cfg_limit);
  assign step             = cmd.walk && !status.walk_done;

  // transitions at or below z are absorbed one per cycle before the run is added
  assign c_take = c_val && (c_ext <= z_ext);
  assign t_take = !c_take && t_val && (t_adj <= z_ext);

  always_comb begin
    nxt = lim_ext;
    if (c_val && (c_ext < nxt)) nxt = c_ext;
    if (t_val && (t_adj < nxt)) nxt = t_adj;
    if (nxt <= z_ext) nxt = z_ext + zs_t'(1);
    if (nxt > lim_ext) nxt = lim_ext;
  end

  assign run_diff = nxt - z_ext;
  assign run_len  = run_diff[Z_BITS-1:0];

  // read address follows the next index so the head is valid the cycle after
  always_comb begin
    ci_next = ci;
    ti_next = ti;
    if (cmd.start || cmd.publish) begin
      ci_next = '0;
      ti_next = '0;
    end else if (step && c_take) begin
      ci_next = ci + CW'(1);
    end else if (step && t_take) begin
      ti_next = ti + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_shift     <= '0;
      cfg_limit     <= Z_LIMIT_RESET;
      carved_count  <= '0;
      target_count  <= '0;
      overflow_flag <= 1'b0;
      ci            <= '0;
      ti            <= '0;
      cin           <= 1'b0;
      tin           <= 1'b0;
      z             <= '0;
      excess_sum    <= '0;
      gouge_sum     <= '0;
      carved_sum    <= '0;
      target_sum    <= '0;
    end else begin
      ci <= ci_next;
      ti <= ti_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_Z_SHIFT: cfg_shift <= cfg_data;
          CFG_Z_LIMIT: cfg_limit <= cfg_data;
          default: ;
        endcase
      end

      if (c_wr) carved_count <= carved_count + CW'(1);
      if (t_wr) target_count <= target_count + CW'(1);
      if ((cmd.load_carved && !c_wr) || (cmd.load_target && !t_wr)) begin
        overflow_flag <= 1'b1;
      end

      if (cmd.start) begin
        cin <= 1'b0;
        tin <= 1'b0;
        z   <= '0;
        if (cmd.clear) begin
          excess_sum <= '0;
          gouge_sum  <= '0;
          carved_sum <= '0;
          target_sum <= '0;
        end
      end else if (step) begin
        if (c_take) begin
          cin <= !cin;
        end else if (t_take) begin
          tin <= !tin;
        end else begin
          z <= nxt[Z_BITS-1:0];
          if (cin) carved_sum <= sat_add(carved_sum, run_len);
          if (tin) target_sum <= sat_add(target_sum, run_len);
          if (cin && !tin) excess_sum <= sat_add(excess_sum, run_len);
          if (tin && !cin) gouge_sum <= sat_add(gouge_sum, run_len);
        end
      end

      if (cmd.publish) begin
        carved_count  <= '0;
        target_count  <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_item.excess_total <= excess_sum;
      out_item.gouge_total  <= gouge_sum;
      out_item.carved_total <= carved_sum;
      out_item.target_total <= target_sum;
      out_item.overflow     <= overflow_flag;
    end
  end

endmodule
`default_nettype wire

// File: rtl/voxel_column_occupancy_diff.sv
// top level: voxel column occupancy difference counter
// Usage:
//   Input channel (in_valid/in_ready, in_item) carries one request per beat:
//   load carved transition, load target transition, or finish column.
//   Loads are written straight into the list rams; a load into a full list
//   is dropped and flags overflow for the column. A finish walks both lists
//   in one sequencer loop: each cycle either absorbs one transition or adds
//   one run to the saturating totals. Its result beat shows on
//   out_valid/out_ready, out_item in the cycle in_ready returns high; no
//   other request yields a beat. in_ready is low from a finish beat until
//   its result is registered. Loads for the next column are taken while a
//   result waits; a stalled receiver holds the next finish once its walk is
//   done.
//   Configuration (cfg_we, cfg_index, cfg_data) is to be written while idle;
//   the block itself does not enforce this. Index 0 is z_shift, index 1 is
//   z_limit; other indexes are ignored.
//   Synchronous reset empties both lists, zeroes the totals, sets z_shift
//   to 0 and z_limit to 4096; list contents are left as they are.
`default_nettype none
module voxel_column_occupancy_diff #(
  parameter int MAX_TRANSITIONS = vcod_pkg::MAX_TRANSITIONS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire vcod_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output vcod_pkg::out_item_t                      out_item,
  input  wire logic                                cfg_we,
  input  wire logic [vcod_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire vcod_pkg::z_t                        cfg_data
);
  import vcod_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  vcod_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (in_item.req_type),
    .clear_totals (in_item.clear_totals),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .status       (status)
  );

  vcod_dp #(.MAX_TRANSITIONS(MAX_TRANSITIONS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .z_value   (in_item.z_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for the voxel column occupancy difference block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vcod_pkg::*;

  localparam int LIST_DEPTH = MAX_TRANSITIONS_DEF;
  localparam int Z_MAX = (1 << Z_BITS) - 1;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 760;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  z_t cfg_data = '0;

  // mirror of the block state
  z_t carved_z [LIST_DEPTH];
  z_t target_z [LIST_DEPTH];
  int carved_n;
  int target_n;
  bit col_overflow;
  total_t excess_acc, gouge_acc, carved_acc, target_acc;
  int shift_amt;
  int limit_amt;
  out_item_t expected_totals[$];

  int fail_count = 0;
  int columns_done = 0;
  int overflow_cols = 0;
  int settings_written = 0;
  int items_sent = 0;
  int noise_sent = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  voxel_column_occupancy_diff i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic total_t sat_add(total_t acc, int len);
    logic [TOTAL_BITS:0] s;
    s = acc;
    s = s + len;
    return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
  endfunction

  function automatic int target_pos(int idx);
    return int'(target_z[idx]) - shift_amt;
  endfunction

  function automatic int clamp_z(int v);
    if (v < 0) return 0;
    if (v > Z_MAX) return Z_MAX;
    return v;
  endfunction

  // run-by-run merge of both transition lists over [0, limit)
  function automatic void accumulate_column();
    int ci, ti, z, nxt, len;
    bit cin, tin;
    ci = 0;
    ti = 0;
    cin = 1'b0;
    tin = 1'b0;
    z = 0;
    while (z < limit_amt) begin
      nxt = limit_amt;
      while (ci < carved_n && int'(carved_z[ci]) <= z) begin
        cin = !cin;
        ci++;
      end
      while (ti < target_n && target_pos(ti) <= z) begin
        tin = !tin;
        ti++;
      end
      if (ci < carved_n && int'(carved_z[ci]) < nxt) nxt = int'(carved_z[ci]);
      if (ti < target_n && target_pos(ti) < nxt) nxt = target_pos(ti);
      // out-of-order entries still move the walk forward by one voxel
      if (nxt <= z) nxt = z + 1;
      if (nxt > limit_amt) nxt = limit_amt;
      len = nxt - z;
      if (cin) carved_acc = sat_add(carved_acc, len);
      if (tin) target_acc = sat_add(target_acc, len);
      if (cin && !tin) excess_acc = sat_add(excess_acc, len);
      if (tin && !cin) gouge_acc = sat_add(gouge_acc, len);
      z = nxt;
    end
  endfunction

  function automatic void predict_request(in_item_t it);
    out_item_t r;
    case (it.req_type)
      REQ_LOAD_CARVED: begin
        if (carved_n < LIST_DEPTH) begin
          carved_z[carved_n] = it.z_value;
          carved_n++;
        end else begin
          col_overflow = 1'b1;
        end
      end
      REQ_LOAD_TARGET: begin
        if (target_n < LIST_DEPTH) begin
          target_z[target_n] = it.z_value;
          target_n++;
        end else begin
          col_overflow = 1'b1;
        end
      end
      REQ_FINISH: begin
        if (it.clear_totals) begin
          excess_acc = '0;
          gouge_acc = '0;
          carved_acc = '0;
          target_acc = '0;
        end
        accumulate_column();
        r.excess_total = excess_acc;
        r.gouge_total = gouge_acc;
        r.carved_total = carved_acc;
        r.target_total = target_acc;
        r.overflow = col_overflow;
        expected_totals.push_back(r);
        columns_done++;
        if (col_overflow) overflow_cols++;
        carved_n = 0;
        target_n = 0;
        col_overflow = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string field, total_t want, total_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (expected_totals.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual excess %0d gouge %0d",
               $time, got.excess_total, got.gouge_total);
      fail_count++;
      return;
    end
    want = expected_totals.pop_front();
    compare_field("excess_total", want.excess_total, got.excess_total);
    compare_field("gouge_total", want.gouge_total, got.gouge_total);
    compare_field("carved_total", want.carved_total, got.carved_total);
    compare_field("target_total", want.target_total, got.target_total);
    compare_field("overflow", total_t'(want.overflow), total_t'(got.overflow));
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_request(in_item);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_item);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d cycles without a beat", $time, stall_cycles);
      $display("voxel_column_occupancy_diff regression: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_req(req_t kind, int z, bit clr);
    in_item_t it;
    it.req_type = kind;
    it.z_value = z[Z_BITS-1:0];
    it.clear_totals = clr;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[Z_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(int shift, int limit);
    write_reg(CFG_Z_SHIFT, shift);
    write_reg(CFG_Z_LIMIT, limit);
    shift_amt = shift;
    limit_amt = limit;
    settings_written++;
  endtask

  // one column: ascending lists (or scrambled), loads interleaved, then a finish
  task automatic send_column(int n_c, int n_t, int span, bit scramble, bit clr);
    int cz[$];
    int tz[$];
    int v, step_max, ci, ti;
    step_max = (2 * span) / (n_c + 1) + 1;
    v = 0;
    repeat (n_c) begin
      if (scramble) begin
        cz.push_back($urandom_range(0, Z_MAX));
      end else begin
        v = v + $urandom_range(0, step_max);
        cz.push_back(clamp_z(v));
      end
    end
    step_max = (2 * span) / (n_t + 1) + 1;
    v = shift_amt;
    repeat (n_t) begin
      if (scramble) begin
        tz.push_back($urandom_range(0, Z_MAX));
      end else begin
        v = v + $urandom_range(0, step_max);
        tz.push_back(clamp_z(v));
      end
    end
    ci = 0;
    ti = 0;
    while (ci < n_c || ti < n_t) begin
      if ($urandom_range(0, 19) == 0) begin
        send_req(req_t'(REQ_UNUSED), $urandom_range(0, Z_MAX), $urandom_range(0, 1));
        noise_sent++;
      end
      if (ti == n_t || (ci < n_c && $urandom_range(0, 1) == 1)) begin
        send_req(REQ_LOAD_CARVED, cz[ci], $urandom_range(0, 1));
        ci++;
      end else begin
        send_req(REQ_LOAD_TARGET, tz[ti], $urandom_range(0, 1));
        ti++;
      end
    end
    send_req(REQ_FINISH, $urandom_range(0, Z_MAX), clr);
    items_sent += n_c + n_t + 1;
  endtask

  task automatic test_directed_cases();
    // empty column
    send_req(REQ_FINISH, 0, 1'b1);
    // overlapping runs
    send_req(REQ_LOAD_CARVED, 10, 1'b0);
    send_req(REQ_LOAD_CARVED, 20, 1'b1);
    send_req(REQ_LOAD_TARGET, 15, 1'b0);
    send_req(REQ_LOAD_TARGET, 30, 1'b1);
    send_req(REQ_FINISH, Z_MAX, 1'b0);
    // extreme z values and an unused request type
    send_req(REQ_LOAD_CARVED, 0, 1'b0);
    send_req(REQ_LOAD_TARGET, Z_MAX, 1'b1);
    send_req(REQ_LOAD_CARVED, Z_MAX, 1'b0);
    send_req(req_t'(REQ_UNUSED), Z_MAX, 1'b1);
    send_req(REQ_FINISH, 0, 1'b0);
    // out-of-order transitions
    send_req(REQ_LOAD_CARVED, 300, 1'b0);
    send_req(REQ_LOAD_CARVED, 100, 1'b0);
    send_req(REQ_LOAD_CARVED, 200, 1'b0);
    send_req(REQ_LOAD_TARGET, 50, 1'b0);
    send_req(REQ_LOAD_TARGET, 5, 1'b0);
    send_req(REQ_FINISH, 0, 1'b1);
    // transitions at the edge of the range
    send_req(REQ_LOAD_CARVED, 4095, 1'b0);
    send_req(REQ_LOAD_CARVED, 4096, 1'b0);
    send_req(REQ_LOAD_TARGET, 4095, 1'b0);
    send_req(REQ_FINISH, 0, 1'b0);
    send_req(req_t'(REQ_UNUSED), 0, 1'b0);
    send_req(REQ_FINISH, 0, 1'b1);
    items_sent += 21;
    noise_sent += 2;
    wait_idle();
  endtask

  task automatic test_register_settings();
    int shifts[6] = '{-4096, 4095, 0, -4096, 4095, -7};
    int limits[6] = '{Z_MAX, 0, 1, 1, 4096, 2500};
    int i;
    for (i = 0; i < 6; i++) begin
      write_settings(shifts[i], limits[i]);
      repeat (3) send_column($urandom_range(0, 6), $urandom_range(0, 6), limits[i] + 2,
                            1'b0, $urandom_range(0, 1));
      wait_idle();
    end
  endtask

  task automatic test_list_overflow();
    write_settings(0, 4096);
    send_column(LIST_DEPTH, LIST_DEPTH, Z_MAX, 1'b0, 1'b1);
    send_column(LIST_DEPTH + 1, 0, 4096, 1'b0, 1'b0);
    send_column(0, LIST_DEPTH + 2, 4096, 1'b0, 1'b0);
    // flag must be gone for the next column
    send_column(2, 2, 100, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (8) send_column($urandom_range(1, 6), $urandom_range(1, 6), 2000, 1'b0, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_columns();
    int phase, budget, r, n_c, n_t, span;
    for (phase = 0; phase < 4; phase++) begin
      // last phase runs with no idling on either side
      if (phase == 3) quiet = 1'b1;
      if (phase > 0)
        write_settings(int'($urandom_range(0, Z_MAX)) - 4096,
                       ($urandom_range(0, 4) == 0) ? Z_MAX : $urandom_range(0, 4096));
      budget = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < budget) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          n_c = $urandom_range(60, 72);
          n_t = $urandom_range(60, 72);
        end else if (r < 14) begin
          n_c = $urandom_range(0, LIST_DEPTH);
          n_t = $urandom_range(0, LIST_DEPTH);
        end else begin
          n_c = $urandom_range(0, 8);
          n_t = $urandom_range(0, 8);
        end
        case ($urandom_range(0, 3))
          0: span = Z_MAX;
          1: span = limit_amt;
          2: span = 300;
          default: span = 40;
        endcase
        send_column(n_c, n_t, span, $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
      end
      wait_idle();
    end
  endtask

  initial begin
    carved_n = 0;
    target_n = 0;
    col_overflow = 1'b0;
    excess_acc = '0;
    gouge_acc = '0;
    carved_acc = '0;
    target_acc = '0;
    shift_amt = 0;
    limit_amt = int'(Z_LIMIT_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_register_settings();
    test_list_overflow();
    test_output_backpressure();
    test_random_columns();

    if (expected_totals.size() != 0) begin
      $display("%0t: %0d column results never arrived", $time, expected_totals.size());
      fail_count++;
    end
    $display("checked %0d column results (%0d with dropped loads) over %0d register settings",
             columns_done, overflow_cols, settings_written);
    $display("sent %0d request beats plus %0d unused-type beats", items_sent, noise_sent);
    if (fail_count == 0) begin
      $display("voxel_column_occupancy_diff regression: pass");
    end else begin
      $display("voxel_column_occupancy_diff regression: fail");
    end
    $finish;
  end

endmodule
